@@ hdl/go_back_n_sender_window_unit_defines.svh @@
// Assertion macros for the go-back-N sender window unit.
// Included by the top level; no other dependencies.
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define GBNS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define GBNS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define GBNS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/gbns_pkg.sv @@
// Shared types and constants of the go-back-N sender window unit.
// No dependencies; used by gbns_alu, gbns_ctrl and the top level.
package gbns_pkg;

   // Shared adder width: 32-bit ack numbers plus one carry bit
   localparam int ALU_W     = 33;
   localparam int IDX_W     = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0]  DUP_LIMIT = 2'd3;
   localparam logic [15:0] TIMER_MAX = 16'hffff;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_START_SEQUENCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS  = 2'd2;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_ACK   = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_SEND  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_INC,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_ACK_SUCC,
      ST_ACK_CMP,
      ST_ACK_IOINC,
      ST_ACK_JINC,
      ST_CLAMP_LO,
      ST_CLAMP_HI,
      ST_ACK_FIN,
      ST_ACK_DUP,
      ST_TICK_INC,
      ST_TICK_CMP,
      ST_SND_CHK0,
      ST_SND_WIN,
      ST_SND_WCMP,
      ST_SND_T1,
      ST_SND_TCMP,
      ST_SND_SPAN,
      ST_SND_LIM,
      ST_RS_PREP,
      ST_RS_EMIT,
      ST_NW_PREP,
      ST_NW_EMIT,
      ST_NW_INC,
      ST_EMPTY
   } fsm_state_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             lt;
      logic             eq;
   } alu_rsp_type;

   typedef struct packed {
      logic [31:0] start_sequence;
      logic [15:0] total_packets;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] ack_number;
      logic [15:0] ack_offset;
      logic        ack_fin;
      logic        ack_good;
   } req_type;

   typedef struct packed {
      logic             send_valid;
      logic [15:0]      packet_index;
      logic [31:0]      sequence_number;
      logic             is_resend;
      logic             is_final_packet;
      logic             transfer_done;
      logic [IDX_W-1:0] window_base;
      logic             last_in_run;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic [IDX_W-1:0] window_start;
      logic [IDX_W-1:0] next_index;
   } stat_type;

endpackage

@@ hdl/gbns_alu.sv @@
// Shared add / subtract / compare unit of the sender window unit.
// Depends on gbns_pkg for the request and response structs.
module gbns_alu (
   input  gbns_pkg::alu_req_type alu_req,
   output gbns_pkg::alu_rsp_type alu_rsp
);
   import gbns_pkg::*;

   logic [ALU_W-1:0] b_eff;
   logic             cin;
   logic             is_sub;
   logic [ALU_W:0]   full;

   // Decode operation into operand inversion and carry in
   always_comb begin
      unique case (alu_req.op)
         ALU_ADD: begin
            b_eff  = alu_req.b;
            cin    = 1'b0;
            is_sub = 1'b0;
         end
         ALU_INC: begin
            b_eff  = alu_req.b;
            cin    = 1'b1;
            is_sub = 1'b0;
         end
         ALU_SUB: begin
            b_eff  = ~alu_req.b;
            cin    = 1'b1;
            is_sub = 1'b1;
         end
         default: begin
            b_eff  = alu_req.b;
            cin    = 1'b0;
            is_sub = 1'b0;
         end
      endcase
   end

   // One adder; borrow of a subtract gives the less-than flag
   assign full        = {1'b0, alu_req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, cin};
   assign alu_rsp.sum = full[ALU_W-1:0];
   assign alu_rsp.lt  = is_sub & ~full[ALU_W];
   assign alu_rsp.eq  = (alu_req.a == alu_req.b);

endmodule

@@ hdl/gbns_ctrl.sv @@
// Sequencer and window state of the sender window unit.
// Depends on gbns_pkg; drives one shared gbns_alu through alu_req / alu_rsp.
module gbns_ctrl #(
   parameter int WINDOW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_take,
   input  gbns_pkg::req_type     req_data,
   input  gbns_pkg::cfg_type     cfg,
   input  logic                  slot_free,
   input  gbns_pkg::alu_rsp_type alu_rsp,
   output gbns_pkg::alu_req_type alu_req,
   output logic                  rsp_wr,
   output gbns_pkg::rsp_type     rsp_data,
   output gbns_pkg::stat_type    stat
);
   import gbns_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

   fsm_state_type    state_ff, state_in;
   logic [31:0]      num_ff, num_in;
   logic [15:0]      off_ff, off_in;
   logic             fin_ff, fin_in;
   logic             good_ff, good_in;

   logic [IDX_W-1:0] ws_ff, ws_in;
   logic [IDX_W-1:0] next_ff, next_in;
   logic [31:0]      last_ff, last_in;
   logic [1:0]       dup_ff, dup_in;
   logic             pend_ff, pend_in;
   logic             done_ff, done_in;
   logic [15:0]      timer_ff, timer_in;

   logic [ALU_W-1:0] tmp_ff, tmp_in;
   logic [IDX_W-1:0] cand_ff, cand_in;
   logic             inorder_ff, inorder_in;
   logic             new_ok_ff, new_ok_in;
   logic             sent_ff, sent_in;
   logic             final_ff, final_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] lim_ff, lim_in;

   logic [15:0]      tick_lim;
   logic [CNT_W-1:0] lim_calc;
   logic             run_end;

   assign tick_lim = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
   assign lim_calc = alu_rsp.lt ? tmp_ff[CNT_W-1:0] : WIN_CNT;
   assign run_end  = (cnt_ff == (lim_ff - CNT_W'(1)));

   assign stat.busy         = (state_ff != ST_IDLE);
   assign stat.window_start = ws_ff;
   assign stat.next_index   = next_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (action_type'(req_data.action))
                  ACT_START: state_in = ST_START;
                  ACT_ACK:   state_in = ST_ACK_SUCC;
                  ACT_TICK:  state_in = ST_TICK_INC;
                  ACT_SEND:  state_in = ST_SND_CHK0;
                  default:   state_in = ST_EMPTY;
               endcase
            end
         end
         ST_START:     state_in = ST_EMPTY;
         ST_ACK_SUCC:  state_in = (good_ff && !done_ff && !fin_ff) ? ST_ACK_CMP : ST_EMPTY;
         ST_ACK_CMP: begin
            if (alu_rsp.eq)       state_in = ST_ACK_IOINC;
            else if (!alu_rsp.lt) state_in = ST_ACK_JINC;
            else                  state_in = ST_ACK_DUP;
         end
         ST_ACK_IOINC: state_in = ST_CLAMP_LO;
         ST_ACK_JINC:  state_in = ST_CLAMP_LO;
         ST_CLAMP_LO:  state_in = ST_CLAMP_HI;
         ST_CLAMP_HI:  state_in = inorder_ff ? ST_ACK_FIN : ST_EMPTY;
         ST_ACK_FIN:   state_in = ST_EMPTY;
         ST_ACK_DUP:   state_in = ST_EMPTY;
         ST_TICK_INC:  state_in = (!pend_ff && !done_ff) ? ST_TICK_CMP : ST_EMPTY;
         ST_TICK_CMP:  state_in = ST_EMPTY;
         ST_SND_CHK0:  state_in = done_ff ? ST_EMPTY : ST_SND_WIN;
         ST_SND_WIN:   state_in = ST_SND_WCMP;
         ST_SND_WCMP:  state_in = pend_ff ? ST_SND_T1 : ST_NW_PREP;
         ST_SND_T1:    state_in = ST_SND_TCMP;
         ST_SND_TCMP:  state_in = alu_rsp.lt ? ST_NW_PREP : ST_SND_SPAN;
         ST_SND_SPAN:  state_in = ST_SND_LIM;
         ST_SND_LIM:   state_in = (lim_calc == '0) ? ST_NW_PREP : ST_RS_PREP;
         ST_RS_PREP:   state_in = ST_RS_EMIT;
         ST_RS_EMIT: begin
            if (slot_free) state_in = run_end ? ST_NW_PREP : ST_RS_PREP;
         end
         ST_NW_PREP: begin
            if (new_ok_ff)    state_in = ST_NW_EMIT;
            else if (sent_ff) state_in = ST_IDLE;
            else              state_in = ST_EMPTY;
         end
         ST_NW_EMIT: begin
            if (slot_free) state_in = ST_NW_INC;
         end
         ST_NW_INC:    state_in = ST_IDLE;
         ST_EMPTY: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath updates, shared unit requests and result writes
   always_comb begin
      num_in     = num_ff;
      off_in     = off_ff;
      fin_in     = fin_ff;
      good_in    = good_ff;
      ws_in      = ws_ff;
      next_in    = next_ff;
      last_in    = last_ff;
      dup_in     = dup_ff;
      pend_in    = pend_ff;
      done_in    = done_ff;
      timer_in   = timer_ff;
      tmp_in     = tmp_ff;
      cand_in    = cand_ff;
      inorder_in = inorder_ff;
      new_ok_in  = new_ok_ff;
      sent_in    = sent_ff;
      final_in   = final_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      lim_in     = lim_ff;

      alu_req.op = ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;

      rsp_wr                   = 1'b0;
      rsp_data.send_valid      = 1'b0;
      rsp_data.packet_index    = '0;
      rsp_data.sequence_number = '0;
      rsp_data.is_resend       = 1'b0;
      rsp_data.is_final_packet = 1'b0;
      rsp_data.transfer_done   = done_ff;
      rsp_data.window_base     = ws_ff;
      rsp_data.last_in_run     = 1'b1;

      unique case (state_ff)
         // Latch the transaction
         ST_IDLE: begin
            if (req_take) begin
               num_in  = req_data.ack_number;
               off_in  = req_data.ack_offset;
               fin_in  = req_data.ack_fin;
               good_in = req_data.ack_good;
               sent_in = 1'b0;
            end
         end
         // Clear the window and load the last ack
         ST_START: begin
            ws_in    = '0;
            next_in  = '0;
            last_in  = cfg.start_sequence;
            dup_in   = '0;
            pend_in  = 1'b0;
            done_in  = 1'b0;
            timer_in = '0;
         end
         // FIN ends the transfer; otherwise form last + 1
         ST_ACK_SUCC: begin
            if (good_ff && !done_ff) begin
               if (fin_ff) begin
                  done_in = 1'b1;
               end else begin
                  alu_req.op = ALU_INC;
                  alu_req.a  = ALU_W'(last_ff);
                  tmp_in     = alu_rsp.sum;
               end
            end
         end
         // Classify: in order, jump or possible duplicate
         ST_ACK_CMP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(num_ff);
            alu_req.b  = tmp_ff;
            inorder_in = alu_rsp.eq;
         end
         ST_ACK_IOINC: begin
            alu_req.op = ALU_INC;
            alu_req.a  = ALU_W'(ws_ff);
            cand_in    = alu_rsp.sum[IDX_W-1:0];
         end
         ST_ACK_JINC: begin
            alu_req.op = ALU_INC;
            alu_req.a  = ALU_W'(off_ff);
            cand_in    = alu_rsp.sum[IDX_W-1:0];
         end
         // Hold base at or above its old value
         ST_CLAMP_LO: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(cand_ff);
            alu_req.b  = ALU_W'(ws_ff);
            if (alu_rsp.lt) cand_in = ws_ff;
         end
         // Hold base at or below next, then commit the ack
         ST_CLAMP_HI: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(next_ff);
            alu_req.b  = ALU_W'(cand_ff);
            ws_in      = alu_rsp.lt ? next_ff : cand_ff;
            last_in    = num_ff;
            dup_in     = '0;
         end
         // Ack of the final packet ends the transfer; else it counts once
         ST_ACK_FIN: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(off_ff);
            alu_req.b  = ALU_W'(cfg.total_packets);
            if (alu_rsp.eq) begin
               done_in = 1'b1;
               dup_in  = '0;
            end else begin
               dup_in  = 2'd1;
            end
         end
         // Count duplicates; arm a resend on the third
         ST_ACK_DUP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(num_ff);
            alu_req.b  = ALU_W'(last_ff);
            if (alu_rsp.eq) begin
               if ((dup_ff + 2'd1) == DUP_LIMIT) begin
                  dup_in  = '0;
                  pend_in = 1'b1;
               end else begin
                  dup_in  = dup_ff + 2'd1;
               end
            end
         end
         // Advance the idle timer, saturating
         ST_TICK_INC: begin
            if (!pend_ff && !done_ff) begin
               alu_req.op = ALU_INC;
               alu_req.a  = ALU_W'(timer_ff);
               if (timer_ff != TIMER_MAX) timer_in = alu_rsp.sum[15:0];
            end
         end
         ST_TICK_CMP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(timer_ff);
            alu_req.b  = ALU_W'(tick_lim);
            if (!alu_rsp.lt) begin
               dup_in  = '0;
               pend_in = 1'b1;
            end
         end
         // New packet allowed: next <= total and next < base + window
         ST_SND_CHK0: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(cfg.total_packets);
            alu_req.b  = ALU_W'(next_ff);
            new_ok_in  = !alu_rsp.lt;
         end
         ST_SND_WIN: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'(ws_ff);
            alu_req.b  = ALU_W'(WIN_CNT);
            tmp_in     = alu_rsp.sum;
         end
         ST_SND_WCMP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(next_ff);
            alu_req.b  = tmp_ff;
            new_ok_in  = new_ok_ff & alu_rsp.lt;
         end
         // Resend only when next <= total + 1
         ST_SND_T1: begin
            alu_req.op = ALU_INC;
            alu_req.a  = ALU_W'(cfg.total_packets);
            tmp_in     = alu_rsp.sum;
         end
         ST_SND_TCMP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = tmp_ff;
            alu_req.b  = ALU_W'(next_ff);
            if (!alu_rsp.lt) pend_in = 1'b0;
         end
         // Run length is min(next - base, window)
         ST_SND_SPAN: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(next_ff);
            alu_req.b  = ALU_W'(ws_ff);
            tmp_in     = alu_rsp.sum;
         end
         ST_SND_LIM: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = tmp_ff;
            alu_req.b  = ALU_W'(WIN_CNT);
            lim_in     = lim_calc;
            cnt_in     = '0;
            idx_in     = ws_ff;
         end
         ST_RS_PREP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(idx_ff);
            alu_req.b  = ALU_W'(cfg.total_packets);
            final_in   = alu_rsp.eq;
         end
         // Order one retransmission
         ST_RS_EMIT: begin
            alu_req.op = ALU_INC;
            alu_req.a  = ALU_W'(cfg.start_sequence);
            alu_req.b  = ALU_W'(idx_ff);
            rsp_data.send_valid      = 1'b1;
            rsp_data.packet_index    = idx_ff[15:0];
            rsp_data.sequence_number = alu_rsp.sum[31:0];
            rsp_data.is_resend       = 1'b1;
            rsp_data.is_final_packet = final_ff;
            rsp_data.last_in_run     = run_end && !new_ok_ff;
            if (slot_free) begin
               rsp_wr   = 1'b1;
               timer_in = '0;
               sent_in  = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               idx_in   = idx_ff + IDX_W'(1);
            end
         end
         ST_NW_PREP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(next_ff);
            alu_req.b  = ALU_W'(cfg.total_packets);
            final_in   = alu_rsp.eq;
         end
         // Order the new packet
         ST_NW_EMIT: begin
            alu_req.op = ALU_INC;
            alu_req.a  = ALU_W'(cfg.start_sequence);
            alu_req.b  = ALU_W'(next_ff);
            rsp_data.send_valid      = 1'b1;
            rsp_data.packet_index    = next_ff[15:0];
            rsp_data.sequence_number = alu_rsp.sum[31:0];
            rsp_data.is_final_packet = final_ff;
            if (slot_free) begin
               rsp_wr   = 1'b1;
               timer_in = '0;
            end
         end
         ST_NW_INC: begin
            alu_req.op = ALU_INC;
            alu_req.a  = ALU_W'(next_ff);
            next_in    = alu_rsp.sum[IDX_W-1:0];
         end
         // Report a transaction that orders nothing
         ST_EMPTY: begin
            rsp_wr = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ws_ff    <= '0;
         next_ff  <= '0;
         last_ff  <= '0;
         dup_ff   <= '0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         timer_ff <= '0;
      end else begin
         state_ff <= state_in;
         ws_ff    <= ws_in;
         next_ff  <= next_in;
         last_ff  <= last_in;
         dup_ff   <= dup_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
         timer_ff <= timer_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      off_ff     <= off_in;
      fin_ff     <= fin_in;
      good_ff    <= good_in;
      tmp_ff     <= tmp_in;
      cand_ff    <= cand_in;
      inorder_ff <= inorder_in;
      new_ok_ff  <= new_ok_in;
      sent_ff    <= sent_in;
      final_ff   <= final_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      lim_ff     <= lim_in;
   end

endmodule

@@ hdl/go_back_n_sender_window_unit.sv @@
// Go-back-N sender window unit: config registers, sequencer, shared adder, output register.
// Depends on gbns_pkg, gbns_alu, gbns_ctrl and go_back_n_sender_window_unit_defines.svh.
// One transaction at a time on one shared 33-bit adder/comparator; req_stall holds from accept
// until the sequencer is idle again, after the last result of the transaction; stalls lengthen it.
// A send writes one result per retransmission and per new packet, or one when nothing is sent.
// Synchronous active-high reset clears window state, config to defaults, no pending result.
`include "go_back_n_sender_window_unit_defines.svh"

module go_back_n_sender_window_unit #(
   parameter int WINDOW = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [gbns_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [31:0]                    req_ack_number,
   input  logic [15:0]                    req_ack_offset,
   input  logic                           req_ack_fin,
   input  logic                           req_ack_good,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_send_valid,
   output logic [15:0]                    rsp_packet_index,
   output logic [31:0]                    rsp_sequence_number,
   output logic                           rsp_is_resend,
   output logic                           rsp_is_final_packet,
   output logic                           rsp_transfer_done,
   output logic [16:0]                    rsp_window_base,
   output logic                           rsp_last_in_run
);
   import gbns_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   req_type     req_data;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   rsp_type     rsp_data;
   stat_type    stat;
   logic        rsp_wr;
   logic        req_take;
   logic        slot_free;

   assign req_data.action     = req_action;
   assign req_data.ack_number = req_ack_number;
   assign req_data.ack_offset = req_ack_offset;
   assign req_data.ack_fin    = req_ack_fin;
   assign req_data.ack_good   = req_ack_good;

   assign req_stall = stat.busy;
   assign req_take  = req_valid && !stat.busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_START_SEQUENCE: cfg_in.start_sequence = csr_wdata;
            CSR_TOTAL_PACKETS:  cfg_in.total_packets  = csr_wdata[15:0];
            CSR_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = csr_wdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_sequence <= '0;
         cfg_ff.total_packets  <= '0;
         cfg_ff.timeout_ticks  <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gbns_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   gbns_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_take  (req_take),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .alu_rsp   (alu_rsp),
      .alu_req   (alu_req),
      .rsp_wr    (rsp_wr),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

   // Output register: load a result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_wr) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_wr) begin
         rsp_data_ff <= rsp_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_send_valid      = rsp_data_ff.send_valid;
   assign rsp_packet_index    = rsp_data_ff.packet_index;
   assign rsp_sequence_number = rsp_data_ff.sequence_number;
   assign rsp_is_resend       = rsp_data_ff.is_resend;
   assign rsp_is_final_packet = rsp_data_ff.is_final_packet;
   assign rsp_transfer_done   = rsp_data_ff.transfer_done;
   assign rsp_window_base     = rsp_data_ff.window_base;
   assign rsp_last_in_run     = rsp_data_ff.last_in_run;

   // Checks
   `GBNS_ASSERT_NXT(a_busy_after_take, clock, reset, req_take, req_stall, "block not busy after take")
   `GBNS_ASSERT_ALWAYS(a_base_le_next, clock, reset, stat.window_start <= stat.next_index, "window base passed next index")
   `GBNS_ASSERT_IMP(a_mid_run_sends, clock, reset, rsp_valid && !rsp_last_in_run, rsp_send_valid, "non-final result orders no packet")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the go-back-N sender window unit: directed and random transactions.
// Depends on gbns_pkg and the go_back_n_sender_window_unit RTL; predicts every packet order.

module tb;
   import gbns_pkg::*;

   localparam int WINDOW       = 8;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 40;

   logic                 clock;
   logic                 reset;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_action;
   logic [31:0]          req_ack_number;
   logic [15:0]          req_ack_offset;
   logic                 req_ack_fin;
   logic                 req_ack_good;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_send_valid;
   logic [15:0]          rsp_packet_index;
   logic [31:0]          rsp_sequence_number;
   logic                 rsp_is_resend;
   logic                 rsp_is_final_packet;
   logic                 rsp_transfer_done;
   logic [16:0]          rsp_window_base;
   logic                 rsp_last_in_run;

   // Predicted window state and register copies
   int unsigned base_idx;
   int unsigned next_idx;
   int unsigned idle_ticks;
   logic [31:0] acked_seq;
   logic [1:0]  dup_acks;
   logic        resend_armed;
   logic        xfer_done;
   logic [31:0] cfg_seq;
   logic [15:0] cfg_last;
   logic [15:0] cfg_timeout;

   rsp_type expected_orders[$];
   int      mismatches   = 0;
   int      quiet_cycles = 0;
   bit      idling_on    = 1'b1;

   go_back_n_sender_window_unit #(.WINDOW(WINDOW)) i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_ack_number      (req_ack_number),
      .req_ack_offset      (req_ack_offset),
      .req_ack_fin         (req_ack_fin),
      .req_ack_good        (req_ack_good),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_packet_index    (rsp_packet_index),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_is_resend       (rsp_is_resend),
      .rsp_is_final_packet (rsp_is_final_packet),
      .rsp_transfer_done   (rsp_transfer_done),
      .rsp_window_base     (rsp_window_base),
      .rsp_last_in_run     (rsp_last_in_run)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stall the result channel at random while idling is on
   always @(posedge clock) begin
      rsp_stall <= idling_on && ($urandom_range(99) < 28);
   end

   // Queue one expected packet order
   task automatic order_packet(input logic valid, input int unsigned idx, input logic resend,
                               input logic last);
      rsp_type r;
      r = '0;
      if (valid) begin
         r.send_valid      = 1'b1;
         r.packet_index    = 16'(idx);
         r.sequence_number = cfg_seq + idx + 32'd1;
         r.is_resend       = resend;
         r.is_final_packet = (idx == cfg_last);
      end
      r.transfer_done = xfer_done;
      r.window_base   = 17'(base_idx);
      r.last_in_run   = last;
      expected_orders.push_back(r);
   endtask

   // Keep a new base between the old base and the next unsent packet
   function automatic int unsigned clamp_base(input int unsigned cand);
      if (cand < base_idx) cand = base_idx;
      if (cand > next_idx) cand = next_idx;
      return cand;
   endfunction

   // Advance the window state for one accepted transaction and queue its orders
   task automatic predict_window(input req_type it);
      logic [32:0] succ;
      int unsigned lim;
      int unsigned n_rs;
      int unsigned k;
      logic        do_rs;
      logic        do_new;
      case (it.action)
         ACT_START: begin
            base_idx     = 0;
            next_idx     = 0;
            acked_seq    = cfg_seq;
            dup_acks     = 2'd0;
            resend_armed = 1'b0;
            xfer_done    = 1'b0;
            idle_ticks   = 0;
         end
         ACT_ACK: begin
            if (it.ack_good && !xfer_done) begin
               succ = {1'b0, acked_seq} + 33'd1;
               if (it.ack_fin) begin
                  xfer_done = 1'b1;
               end else begin
                  // in-order ack moves the base by one; the final packet ends the transfer
                  if ({1'b0, it.ack_number} == succ) begin
                     base_idx  = clamp_base(base_idx + 1);
                     acked_seq = it.ack_number;
                     dup_acks  = 2'd0;
                     if (it.ack_offset == cfg_last) xfer_done = 1'b1;
                  end
                  if (!xfer_done) begin
                     if (it.ack_number == acked_seq) begin
                        dup_acks = dup_acks + 2'd1;
                        if (dup_acks == DUP_LIMIT) begin
                           dup_acks     = 2'd0;
                           resend_armed = 1'b1;
                        end
                     end
                     // cumulative jump, compared without wrapping
                     if ({1'b0, it.ack_number} > {1'b0, acked_seq} + 33'd1) begin
                        base_idx  = clamp_base(32'(it.ack_offset) + 1);
                        acked_seq = it.ack_number;
                        dup_acks  = 2'd0;
                     end
                  end
               end
            end
         end
         ACT_TICK: begin
            if (!resend_armed && !xfer_done) begin
               lim = (cfg_timeout == 16'd0) ? 1 : cfg_timeout;
               if (idle_ticks < TIMER_MAX) idle_ticks++;
               if (idle_ticks >= lim) begin
                  dup_acks     = 2'd0;
                  resend_armed = 1'b1;
               end
            end
         end
         ACT_SEND: begin
            if (xfer_done) begin
               order_packet(1'b0, 0, 1'b0, 1'b1);
            end else begin
               do_rs  = resend_armed && (next_idx <= cfg_last + 1);
               n_rs   = 0;
               if (do_rs) n_rs = (next_idx - base_idx < WINDOW) ? next_idx - base_idx : WINDOW;
               do_new = (next_idx <= cfg_last) && (next_idx < base_idx + WINDOW);
               for (k = 0; k < n_rs; k++)
                  order_packet(1'b1, base_idx + k, 1'b1, (k == n_rs - 1) && !do_new);
               if (do_rs) resend_armed = 1'b0;
               if (do_new) begin
                  order_packet(1'b1, next_idx, 1'b0, 1'b1);
                  next_idx++;
               end
               if (n_rs != 0 || do_new) idle_ticks = 0;
               else order_packet(1'b0, 0, 1'b0, 1'b1);
            end
         end
      endcase
      if (it.action != ACT_SEND) order_packet(1'b0, 0, 1'b0, 1'b1);
   endtask

   function automatic req_type make_item(input logic [1:0] action, input logic [31:0] num,
                                         input logic [15:0] off, input logic fin,
                                         input logic good);
      req_type it;
      it.action     = action;
      it.ack_number = num;
      it.ack_offset = off;
      it.ack_fin    = fin;
      it.ack_good   = good;
      return it;
   endfunction

   // Drive one transaction, hold it until accepted, then predict it
   task automatic send_item(input req_type it);
      if (idling_on && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= it.action;
      req_ack_number <= it.ack_number;
      req_ack_offset <= it.ack_offset;
      req_ack_fin    <= it.ack_fin;
      req_ack_good   <= it.ack_good;
      do @(posedge clock); while (req_stall);
      predict_window(it);
   endtask

   task automatic do_start();
      send_item(make_item(ACT_START, $urandom(), 16'($urandom()), 1'($urandom()), 1'b1));
   endtask

   task automatic do_send();
      send_item(make_item(ACT_SEND, $urandom(), 16'($urandom()), 1'($urandom()), 1'b1));
   endtask

   task automatic do_tick();
      send_item(make_item(ACT_TICK, $urandom(), 16'($urandom()), 1'($urandom()), 1'b1));
   endtask

   task automatic do_ack(input logic [31:0] num, input logic [15:0] off);
      send_item(make_item(ACT_ACK, num, off, 1'b0, 1'b1));
   endtask

   // Drop valid and wait until every order has arrived and the unit takes requests
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_orders.size() != 0 || req_stall);
   endtask

   task automatic write_regs(input logic [31:0] seq, input logic [15:0] last,
                             input logic [15:0] tmo);
      csr_wen   <= 1'b1;
      csr_index <= CSR_START_SEQUENCE;
      csr_wdata <= seq;
      @(posedge clock);
      cfg_seq    = seq;
      csr_index <= CSR_TOTAL_PACKETS;
      csr_wdata <= {16'd0, last};
      @(posedge clock);
      cfg_last   = last;
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= {16'd0, tmo};
      @(posedge clock);
      cfg_timeout = tmo;
      csr_wen    <= 1'b0;
   endtask

   // Register defaults: one packet, long timeout
   task automatic test_reset_defaults();
      do_tick();
      do_send();
      do_ack(32'd1, 16'd0);
   endtask

   // Full window, fast retransmit, timeout, sequence wrap, FIN
   task automatic test_window_resend();
      wait_idle();
      write_regs(32'hffff_fffc, 16'd9, 16'd1);
      do_start();
      repeat (9) do_send();
      // in-order ack counts as the first duplicate, two more arm the resend
      repeat (3) do_ack(32'hffff_fffd, 16'd0);
      do_send();
      do_ack(32'hffff_ffff, 16'd2);
      // last ack at the top of the range: neither in order nor a jump
      do_ack(32'd0, 16'd3);
      do_tick();
      do_send();
      send_item(make_item(ACT_ACK, 32'hffff_ffff, 16'hffff, 1'b1, 1'b0));
      send_item(make_item(ACT_ACK, 32'd0, 16'd0, 1'b1, 1'b1));
      do_tick();
      do_send();
   endtask

   // Base clamp both ways, resend held past total, final packet ack
   task automatic test_clamp_and_hold();
      wait_idle();
      write_regs(32'd0, 16'd3, 16'd1);
      do_start();
      do_send();
      do_send();
      do_ack(32'd5, 16'd9);
      do_ack(32'd7, 16'd0);
      do_tick();
      wait_idle();
      write_regs(32'd0, 16'd0, 16'd1);
      do_send();
      wait_idle();
      write_regs(32'd0, 16'd3, 16'd1);
      do_send();
      do_send();
      do_ack(32'd8, 16'd3);
   endtask

   // Phases of mostly well-formed traffic under random register settings
   task automatic test_random_phases();
      req_type     it;
      int unsigned r;
      int unsigned span;
      int unsigned k;
      int          counted;
      int          ph;
      logic [31:0] seq;
      logic [15:0] last;
      logic [15:0] tmo;
      for (ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         idling_on = (ph != 4);
         if (ph == 0) begin
            seq  = 32'hffff_ffff;
            last = 16'hffff;
            tmo  = 16'hffff;
         end else begin
            case ($urandom_range(4))
               0:       seq = 32'd0;
               1:       seq = 32'hffff_ffff;
               2:       seq = 32'hffff_ffff - $urandom_range(40);
               default: seq = $urandom();
            endcase
            case ($urandom_range(4))
               0:       last = 16'd0;
               1:       last = 16'hffff;
               default: last = 16'($urandom_range(24, 1));
            endcase
            case ($urandom_range(5))
               0:       tmo = 16'd1;
               1:       tmo = 16'hffff;
               default: tmo = 16'($urandom_range(4, 1));
            endcase
         end
         write_regs(seq, last, tmo);
         // keep the old window now and then so the new settings act on it
         if (ph == 0 || $urandom_range(3) != 0) do_start();
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            it = make_item(ACT_ACK, $urandom(), 16'($urandom()), 1'b0, 1'b1);
            r  = $urandom_range(99);
            if (xfer_done) begin
               if (r < 70) begin
                  it.action = ACT_START;
               end else begin
                  it.action   = 2'($urandom_range(3));
                  it.ack_fin  = 1'($urandom());
                  it.ack_good = 1'($urandom());
               end
            end else if (r < 35) begin
               it.action = ACT_SEND;
            end else if (r < 55) begin
               it.ack_number = acked_seq + 32'd1;
               it.ack_offset = 16'(base_idx);
            end else if (r < 65) begin
               it.ack_number = acked_seq;
            end else if (r < 75) begin
               span          = next_idx - base_idx;
               k             = $urandom_range(span + 2, 2);
               it.ack_number = acked_seq + k;
               it.ack_offset = 16'(base_idx + k - 1);
            end else if (r < 85) begin
               it.action = ACT_TICK;
            end else if (r < 88) begin
               it.ack_fin = 1'b1;
            end else if (r < 90) begin
               it.action = ACT_START;
            end else if (r < 93) begin
               it.ack_good = 1'b0;
            end else begin
               it.action   = 2'($urandom_range(3));
               it.ack_fin  = 1'($urandom());
               it.ack_good = 1'($urandom());
            end
            // ignored transactions do not advance the count
            if (!(xfer_done && it.action != ACT_START) && !(it.action == ACT_ACK && !it.ack_good))
               counted++;
            send_item(it);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Compare each accepted order with the oldest expectation; watch for a hang
   always @(posedge clock) begin : check_orders
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_orders.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected order, expected none, actual index %h send %b",
                     $time, rsp_packet_index, rsp_send_valid);
         end else begin
            want = expected_orders.pop_front();
            check_field("send_valid", want.send_valid, rsp_send_valid);
            check_field("packet_index", want.packet_index, rsp_packet_index);
            check_field("sequence_number", want.sequence_number, rsp_sequence_number);
            check_field("is_resend", want.is_resend, rsp_is_resend);
            check_field("is_final_packet", want.is_final_packet, rsp_is_final_packet);
            check_field("transfer_done", want.transfer_done, rsp_transfer_done);
            check_field("window_base", want.window_base, rsp_window_base);
            check_field("last_in_run", want.last_in_run, rsp_last_in_run);
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** go_back_n_sender_window_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      csr_wen        <= 1'b0;
      csr_index      <= CSR_START_SEQUENCE;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_action     <= ACT_START;
      req_ack_number <= '0;
      req_ack_offset <= '0;
      req_ack_fin    <= 1'b0;
      req_ack_good   <= 1'b0;
      rsp_stall      <= 1'b0;
      cfg_seq      = '0;
      cfg_last     = '0;
      cfg_timeout  = 16'd1000;
      base_idx     = 0;
      next_idx     = 0;
      idle_ticks   = 0;
      acked_seq    = '0;
      dup_acks     = 2'd0;
      resend_armed = 1'b0;
      xfer_done    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_window_resend();
      test_clamp_and_hold();
      test_random_phases();

      // drain, then give stray orders time to show up
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && expected_orders.size() == 0) begin
         $display("** go_back_n_sender_window_unit: PASSED **");
      end else begin
         $display("** go_back_n_sender_window_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/gbns_pkg.sv
hdl/gbns_alu.sv
hdl/gbns_ctrl.sv
hdl/go_back_n_sender_window_unit.sv
tb/tb.sv
